/* hw/rtl/rhc_pkg.sv */
// Shared constants for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

    // Width of the gray threshold register.
    localparam int CFG_BITS = 16;

    // Reset value of the gray threshold register.
    localparam logic [CFG_BITS-1:0] GRAY_THRESHOLD_RESET = 16'd6;

endpackage

`default_nettype wire

/* hw/rtl/rhc_front.sv */
// Front stage: max/min search, gray test and divider operand setup.
`default_nettype none

module rhc_front
    import rhc_pkg::*;
#(
    parameter int W = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [CFG_BITS-1:0] i_threshold,
    input  wire logic                i_valid,
    output logic                     o_up_ready,
    input  wire logic [W-1:0]        i_red,
    input  wire logic [W-1:0]        i_green,
    input  wire logic [W-1:0]        i_blue,
    input  wire logic [W-1:0]        i_alpha,
    output logic                     o_valid,
    input  wire logic                i_dn_ready,
    output logic [W+2:0]             o_sat_rem,
    output logic [W+2:0]             o_sat_div,
    output logic [W-1:0]             o_sat_low,
    output logic [W+2:0]             o_hue_rem,
    output logic [W+2:0]             o_hue_div,
    output logic [W-1:0]             o_hue_low,
    output logic [2*W-1:0]           o_pass
);

    localparam int DW = W + 3;
    localparam int EW = (W > CFG_BITS) ? W : CFG_BITS;

    logic           w_red_max;
    logic           w_green_max;
    logic [W-1:0]   w_hi;
    logic [W-1:0]   w_lo;
    logic [W-1:0]   w_d;
    logic           w_gray;
    logic [DW-1:0]  w_d_ext;
    logic [DW-1:0]  w_d6;
    logic [DW-1:0]  w_off;
    logic [DW-1:0]  w_plus;
    logic [DW-1:0]  w_minus;
    logic [DW-1:0]  w_num;
    logic [2*W-1:0] w_sat_num;

    logic           r_valid;
    logic [DW-1:0]  r_sat_rem;
    logic [DW-1:0]  r_sat_div;
    logic [W-1:0]   r_sat_low;
    logic [DW-1:0]  r_hue_rem;
    logic [DW-1:0]  r_hue_div;
    logic [2*W-1:0] r_pass;

    // Largest channel, with red winning ties over green and green over blue.
    always_comb begin
        w_red_max   = (i_red >= i_green) && (i_red >= i_blue);
        w_green_max = !w_red_max && (i_green >= i_blue);
        if (w_red_max) begin
            w_hi = i_red;
        end else if (w_green_max) begin
            w_hi = i_green;
        end else begin
            w_hi = i_blue;
        end
        if ((i_red <= i_green) && (i_red <= i_blue)) begin
            w_lo = i_red;
        end else if (i_green <= i_blue) begin
            w_lo = i_green;
        end else begin
            w_lo = i_blue;
        end
        w_d    = w_hi - w_lo;
        w_gray = EW'(w_d) <= EW'(i_threshold);
    end

    // Hue numerator: sector offset plus a signed channel difference, taken modulo 2^DW.
    always_comb begin
        w_d_ext = DW'(w_d);
        w_d6    = (w_d_ext << 2) + (w_d_ext << 1);
        if (w_red_max) begin
            w_off   = (i_green >= i_blue) ? '0 : w_d6;
            w_plus  = DW'(i_green);
            w_minus = DW'(i_blue);
        end else if (w_green_max) begin
            w_off   = w_d_ext << 1;
            w_plus  = DW'(i_blue);
            w_minus = DW'(i_red);
        end else begin
            w_off   = w_d_ext << 2;
            w_plus  = DW'(i_red);
            w_minus = DW'(i_green);
        end
        w_num     = w_off + w_plus - w_minus;
        w_sat_num = {w_d, {W{1'b0}}} - {{W{1'b0}}, w_d};
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_valid;
        end
    end

    // Divider operands; a gray pixel gets a zero dividend over a divisor of one.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_up_ready) begin
            r_pass <= {i_alpha, w_hi};
            if (w_gray) begin
                r_sat_rem <= '0;
                r_sat_low <= '0;
                r_sat_div <= DW'(1);
                r_hue_rem <= '0;
                r_hue_div <= DW'(1);
            end else begin
                r_sat_rem <= DW'(w_sat_num[2*W-1:W]);
                r_sat_low <= w_sat_num[W-1:0];
                r_sat_div <= DW'(w_hi);
                r_hue_rem <= w_num;
                r_hue_div <= w_d6;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_div = r_sat_div;
    assign o_sat_low = r_sat_low;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_div = r_hue_div;
    assign o_hue_low = '0;
    assign o_pass    = r_pass;

endmodule

`default_nettype wire

/* hw/rtl/rhc_div_cell.sv */
// One restoring division step for the saturation and hue lanes, with a pipeline register.
`default_nettype none

module rhc_div_cell #(
    parameter int W = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_up_ready,
    input  wire logic [W+2:0]   i_sat_rem,
    input  wire logic [W+2:0]   i_sat_div,
    input  wire logic [W-1:0]   i_sat_low,
    input  wire logic [W+2:0]   i_hue_rem,
    input  wire logic [W+2:0]   i_hue_div,
    input  wire logic [W-1:0]   i_hue_low,
    input  wire logic [2*W-1:0] i_pass,
    output logic                o_valid,
    input  wire logic           i_dn_ready,
    output logic [W+2:0]        o_sat_rem,
    output logic [W+2:0]        o_sat_div,
    output logic [W-1:0]        o_sat_low,
    output logic [W+2:0]        o_hue_rem,
    output logic [W+2:0]        o_hue_div,
    output logic [W-1:0]        o_hue_low,
    output logic [2*W-1:0]      o_pass
);

    localparam int DW = W + 3;

    logic [DW:0]    w_sat_t;
    logic [DW:0]    w_hue_t;
    logic           w_sat_ge;
    logic           w_hue_ge;
    logic [DW-1:0]  w_sat_diff;
    logic [DW-1:0]  w_hue_diff;

    logic           r_valid;
    logic [DW-1:0]  r_sat_rem;
    logic [DW-1:0]  r_sat_div;
    logic [W-1:0]   r_sat_low;
    logic [DW-1:0]  r_hue_rem;
    logic [DW-1:0]  r_hue_div;
    logic [W-1:0]   r_hue_low;
    logic [2*W-1:0] r_pass;

    // Shift the next dividend bit into the remainder and try the subtraction.
    // The difference is only kept when it is not negative, so it fits in DW bits.
    always_comb begin
        w_sat_t    = {i_sat_rem, i_sat_low[W-1]};
        w_hue_t    = {i_hue_rem, i_hue_low[W-1]};
        w_sat_diff = w_sat_t[DW-1:0] - i_sat_div;
        w_hue_diff = w_hue_t[DW-1:0] - i_hue_div;
        w_sat_ge   = w_sat_t >= {1'b0, i_sat_div};
        w_hue_ge   = w_hue_t >= {1'b0, i_hue_div};
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    // Valid flag of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_valid;
        end
    end

    // New remainder, and the quotient bit enters at the bottom of the dividend word.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_up_ready) begin
            r_sat_rem <= w_sat_ge ? w_sat_diff : w_sat_t[DW-1:0];
            r_hue_rem <= w_hue_ge ? w_hue_diff : w_hue_t[DW-1:0];
            r_sat_low <= {i_sat_low[W-2:0], w_sat_ge};
            r_hue_low <= {i_hue_low[W-2:0], w_hue_ge};
            r_sat_div <= i_sat_div;
            r_hue_div <= i_hue_div;
            r_pass    <= i_pass;
        end
    end

    assign o_valid   = r_valid;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_div = r_sat_div;
    assign o_sat_low = r_sat_low;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_div = r_hue_div;
    assign o_hue_low = r_hue_low;
    assign o_pass    = r_pass;

    // The partial remainder always stays below its divisor.
    a_sat_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_sat_rem < r_sat_div))
        else $error("saturation remainder not below divisor");

    a_hue_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_hue_rem < r_hue_div))
        else $error("hue remainder not below divisor");

    // A stalled cell keeps its partial quotient.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_dn_ready) |=> ($stable(r_sat_low) && $stable(r_hue_low)))
        else $error("cell contents changed during a stall");

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV converter: configuration register, front stage and divider chain.
//
// Usage:
// - Slave stream (i_s_tvalid, o_s_tready, i_s_tdata) carries one RGBA pixel per transaction;
//   master stream (o_m_tvalid, i_m_tready, o_m_tdata) carries one HSV pixel per transaction.
// - i_cfg_we writes i_cfg_wdata into the gray threshold at the clock edge; write only while
//   the block is idle. The threshold resets to 6.
// - From input transaction to output valid, a pixel passes one front stage (max/min, gray
//   test, operand setup) and then one cell per quotient bit. Each cell does one restoring
//   step for both the saturation and the hue division. Every stage is a register with its
//   own valid bit. Throughput is one pixel per cycle while the receiver does not stall.
// - When the receiver stalls, each stage holds while its successor is full, and empty stages
//   further up keep taking transactions until the whole chain is full; then o_s_tready drops.
// - Reset clears all valid bits; the chain is empty and ready right after reset.
// - A pixel whose spread is at or below the threshold yields zero hue and saturation.
`default_nettype none

module rgb_to_hsv_converter
    import rhc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [CFG_BITS-1:0]                 i_cfg_wdata,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // Fields from bit 0 up: red, green, blue, alpha; zero padding to whole bytes.
    input  wire logic [((4*CHANNEL_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // Fields from bit 0 up: hue, saturation, brightness, alpha_out; zero padding.
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]      o_m_tdata
);

    localparam int W  = CHANNEL_BITS;
    localparam int DW = W + 3;
    localparam int TW = ((4*W+7)/8)*8;

    logic [CFG_BITS-1:0] r_gray_threshold;

    logic           w_valid [0:W];
    logic           w_ready [0:W];
    logic [DW-1:0]  w_sat_rem [0:W];
    logic [DW-1:0]  w_sat_div [0:W];
    logic [W-1:0]   w_sat_low [0:W];
    logic [DW-1:0]  w_hue_rem [0:W];
    logic [DW-1:0]  w_hue_div [0:W];
    logic [W-1:0]   w_hue_low [0:W];
    logic [2*W-1:0] w_pass [0:W];

    // Gray threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_threshold <= GRAY_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_gray_threshold <= i_cfg_wdata;
        end
    end

    // Front stage.
    rhc_front #(.W(W)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_gray_threshold),
        .i_valid     (i_s_tvalid),
        .o_up_ready  (o_s_tready),
        .i_red       (i_s_tdata[W-1:0]),
        .i_green     (i_s_tdata[2*W-1:W]),
        .i_blue      (i_s_tdata[3*W-1:2*W]),
        .i_alpha     (i_s_tdata[4*W-1:3*W]),
        .o_valid     (w_valid[0]),
        .i_dn_ready  (w_ready[0]),
        .o_sat_rem   (w_sat_rem[0]),
        .o_sat_div   (w_sat_div[0]),
        .o_sat_low   (w_sat_low[0]),
        .o_hue_rem   (w_hue_rem[0]),
        .o_hue_div   (w_hue_div[0]),
        .o_hue_low   (w_hue_low[0]),
        .o_pass      (w_pass[0])
    );

    // Divider chain, one cell per quotient bit.
    for (genvar k = 0; k < W; k++) begin : g_cell
        rhc_div_cell #(.W(W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_valid[k]),
            .o_up_ready (w_ready[k]),
            .i_sat_rem  (w_sat_rem[k]),
            .i_sat_div  (w_sat_div[k]),
            .i_sat_low  (w_sat_low[k]),
            .i_hue_rem  (w_hue_rem[k]),
            .i_hue_div  (w_hue_div[k]),
            .i_hue_low  (w_hue_low[k]),
            .i_pass     (w_pass[k]),
            .o_valid    (w_valid[k+1]),
            .i_dn_ready (w_ready[k+1]),
            .o_sat_rem  (w_sat_rem[k+1]),
            .o_sat_div  (w_sat_div[k+1]),
            .o_sat_low  (w_sat_low[k+1]),
            .o_hue_rem  (w_hue_rem[k+1]),
            .o_hue_div  (w_hue_div[k+1]),
            .o_hue_low  (w_hue_low[k+1]),
            .o_pass     (w_pass[k+1])
        );
    end

    // The last cell's register is the output register.
    assign w_ready[W]  = i_m_tready;
    assign o_m_tvalid  = w_valid[W];
    assign o_m_tdata   = TW'({w_pass[W], w_sat_low[W], w_hue_low[W]});

    // A black pixel is always gray.
    a_black_is_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[3*W-1:2*W] == '0))
            |-> (o_m_tdata[2*W-1:0] == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire
